/* sv/waypoint_pose_interpolator_unit_macros.svh */
// Assertion macros for the waypoint pose interpolator checker.
`ifndef WAYPOINT_POSE_INTERPOLATOR_UNIT_MACROS_SVH
`define WAYPOINT_POSE_INTERPOLATOR_UNIT_MACROS_SVH
// Same-cycle implication, sampled on i_clk, off during reset.
`define WPI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wpi same-cycle check failed");
// Next-cycle implication, sampled on i_clk, off during reset.
`define WPI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wpi next-cycle check failed");
`endif

/* sv/wpi_pkg.sv */
// Package of types and constants for the waypoint pose interpolator.
`default_nettype none
package wpi_pkg;
    localparam int WP_MAX = 512;
    localparam int WP_AW  = $clog2(WP_MAX);
    localparam int CNT_W  = ($clog2(WP_MAX + 1) > 10) ? $clog2(WP_MAX + 1) : 10;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_LOAD  = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_PERIOD = 1'b0,
        CFG_COUNT  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_B, S_LAT_B, S_LAT_A, S_DIV_STEPS, S_T_START, S_DIV_T,
        S_MUL, S_ACC, S_FINISH
    } t_state;

    typedef struct packed {
        logic [15:0]        dur;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [20:0] z;
        logic signed [20:0] y;
        logic signed [20:0] x;
    } t_wp;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

/* sv/wpi_div.sv */
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module wpi_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wpi_pkg::t_div_req i_req,
    output wpi_pkg::t_div_rsp      o_rsp
);
    import wpi_pkg::*;

    logic [16:0] r_rem;
    logic [31:0] r_quo;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem[15:0], r_quo[31]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_quo <= {r_quo[30:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

/* sv/waypoint_pose_interpolator_unit.sv */
// Top level of the waypoint pose interpolator: store, sequencer, shared multiplier.
// Every transaction yields one result, strobed on o_result_valid for one cycle; the
// receiver cannot stall it. Start, stop, load and an idle tick leave o_busy low and the
// next command may follow at once. A running tick reads two store entries, runs the
// shared serial divider twice (steps, then the fraction) and the shared multiplier
// once per axis (S_MUL, then S_ACC), with o_busy high throughout.
`default_nettype none
module waypoint_pose_interpolator_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [8:0]         i_wp_index,
    input  wire logic signed [20:0] i_wp_x,
    input  wire logic signed [20:0] i_wp_y,
    input  wire logic signed [20:0] i_wp_z,
    input  wire logic signed [15:0] i_wp_roll,
    input  wire logic signed [15:0] i_wp_pitch,
    input  wire logic signed [15:0] i_wp_yaw,
    input  wire logic [15:0]        i_wp_duration_ms,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [9:0]         i_cfg_data,
    output logic                    o_result_valid,
    output logic signed [20:0]      o_pos_x,
    output logic signed [20:0]      o_pos_y,
    output logic signed [20:0]      o_pos_z,
    output logic signed [15:0]      o_ang_roll,
    output logic signed [15:0]      o_ang_pitch,
    output logic signed [15:0]      o_ang_yaw,
    output logic                    o_pose_valid,
    output logic                    o_traj_active,
    output logic                    o_traj_running
);
    import wpi_pkg::*;

    t_wp              r_mem [WP_MAX];
    t_wp              r_rd, r_a, r_b;
    logic [WP_AW-1:0] rd_addr;

    t_state           r_state, n_state;
    logic [WP_AW-1:0] r_seg, n_seg;
    logic [15:0]      r_step, n_step;
    logic [15:0]      r_steps, n_steps;
    logic [16:0]      r_t, n_t;
    logic [2:0]       r_axis, n_axis;
    logic             r_valid, n_valid;
    logic             r_active, n_active;
    logic             r_run, n_run;
    logic             r_strobe, n_strobe;
    logic [9:0]       r_period, r_count;
    logic signed [39:0] r_prod;

    logic             accept, do_load, lat_b, lat_a;
    logic [CNT_W-1:0] cnt_sat;
    logic [CNT_W-1:0] seg_next;
    logic [9:0]       period_eff;
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic signed [21:0] a_v, b_v, diff;
    logic signed [23:0] pose;

    assign accept      = i_start && !o_busy;
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign do_load     = accept && (t_cmd'(i_cmd) == CMD_LOAD) && !r_run &&
                         (32'(i_wp_index) < WP_MAX);

    // effective register values
    assign cnt_sat    = (CNT_W'(r_count) > CNT_W'(WP_MAX)) ? CNT_W'(WP_MAX)
                                                           : CNT_W'(r_count);
    assign seg_next   = CNT_W'(r_seg) + CNT_W'(1);
    assign period_eff = (r_period == 10'd0) ? 10'd1 : r_period;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 10'd50;
            r_count  <= 10'd0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_COUNT:  r_count  <= i_cfg_data;
                default:    r_count  <= r_count;
            endcase
        end
    end

    // waypoint store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_mem[WP_AW'(i_wp_index)] <= '{dur: i_wp_duration_ms, yaw: i_wp_yaw,
                pitch: i_wp_pitch, roll: i_wp_roll, z: i_wp_z, y: i_wp_y, x: i_wp_x};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign rd_addr = (r_state == S_RD_B) ? WP_AW'(seg_next) : r_seg;
    assign lat_b   = (r_state == S_LAT_B);
    assign lat_a   = (r_state == S_LAT_A);

    // segment endpoints
    always_ff @(posedge i_clk) begin
        if (lat_b) r_b <= r_rd;
        if (lat_a) r_a <= r_rd;
    end

    // shared divider
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {16'd0, r_b.dur};
        div_req.divisor  = {6'd0, period_eff};
        if (lat_a) begin
            div_req.start = 1'b1;
        end else if (r_state == S_T_START) begin
            div_req.start    = 1'b1;
            div_req.dividend = {r_step, 16'd0};
            div_req.divisor  = r_steps;
        end
    end

    wpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // axis select and shared multiplier
    always_comb begin
        case (r_axis)
            3'd0:    begin a_v = 22'(r_a.x);     b_v = 22'(r_b.x);     end
            3'd1:    begin a_v = 22'(r_a.y);     b_v = 22'(r_b.y);     end
            3'd2:    begin a_v = 22'(r_a.z);     b_v = 22'(r_b.z);     end
            3'd3:    begin a_v = 22'(r_a.roll);  b_v = 22'(r_b.roll);  end
            3'd4:    begin a_v = 22'(r_a.pitch); b_v = 22'(r_b.pitch); end
            default: begin a_v = 22'(r_a.yaw);   b_v = 22'(r_b.yaw);   end
        endcase
    end

    assign diff = b_v - a_v;
    assign pose = 24'(a_v) + r_prod[39:16];

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) r_prod <= diff * $signed({1'b0, r_t});
    end

    // held pose
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pos_x     <= '0;
            o_pos_y     <= '0;
            o_pos_z     <= '0;
            o_ang_roll  <= '0;
            o_ang_pitch <= '0;
            o_ang_yaw   <= '0;
        end else if (r_state == S_ACC) begin
            case (r_axis)
                3'd0:    o_pos_x     <= pose[20:0];
                3'd1:    o_pos_y     <= pose[20:0];
                3'd2:    o_pos_z     <= pose[20:0];
                3'd3:    o_ang_roll  <= pose[15:0];
                3'd4:    o_ang_pitch <= pose[15:0];
                default: o_ang_yaw   <= pose[15:0];
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seg    <= '0;
            r_step   <= '0;
            r_steps  <= 16'd1;
            r_t      <= '0;
            r_axis   <= '0;
            r_valid  <= 1'b0;
            r_active <= 1'b0;
            r_run    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seg    <= n_seg;
            r_step   <= n_step;
            r_steps  <= n_steps;
            r_t      <= n_t;
            r_axis   <= n_axis;
            r_valid  <= n_valid;
            r_active <= n_active;
            r_run    <= n_run;
            r_strobe <= n_strobe;
        end
    end

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_seg    = r_seg;
        n_step   = r_step;
        n_steps  = r_steps;
        n_t      = r_t;
        n_axis   = r_axis;
        n_valid  = r_valid;
        n_active = r_active;
        n_run    = r_run;
        n_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    case (t_cmd'(i_cmd))
                        CMD_TICK: begin
                            if (r_run) begin
                                if (cnt_sat < CNT_W'(2) || seg_next >= cnt_sat) begin
                                    n_valid  = 1'b0;
                                    n_active = 1'b0;
                                    n_run    = 1'b0;
                                end else begin
                                    n_strobe = 1'b0;
                                    n_state  = S_RD_B;
                                end
                            end
                        end
                        CMD_START: begin
                            if (!r_run) begin
                                n_active = 1'b1;
                                n_run    = 1'b1;
                                n_seg    = '0;
                                n_step   = '0;
                            end
                        end
                        CMD_STOP: begin
                            n_valid  = 1'b0;
                            n_active = 1'b0;
                            n_run    = 1'b0;
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            S_RD_B:  n_state = S_LAT_B;
            S_LAT_B: n_state = S_LAT_A;
            S_LAT_A: n_state = S_DIV_STEPS;
            S_DIV_STEPS: begin
                if (div_rsp.done) begin
                    n_steps = (div_rsp.quotient[15:0] == 16'd0) ? 16'd1
                                                                : div_rsp.quotient[15:0];
                    n_state = S_T_START;
                end
            end
            S_T_START: n_state = S_DIV_T;
            S_DIV_T: begin
                if (div_rsp.done) begin
                    n_t     = div_rsp.quotient[16:0];
                    n_axis  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                if (r_axis == 3'd5) begin
                    n_state = S_FINISH;
                end else begin
                    n_axis  = r_axis + 3'd1;
                    n_state = S_MUL;
                end
            end
            S_FINISH: begin
                n_valid  = 1'b1;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_step >= r_steps) begin
                    n_step = '0;
                    n_seg  = WP_AW'(seg_next);
                end else begin
                    n_step = r_step + 16'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_result_valid = r_strobe;
    assign o_pose_valid   = r_valid;
    assign o_traj_active  = r_active;
    assign o_traj_running = r_run;
endmodule
`default_nettype wire

/* sv/wpi_chk.sv */
// Port-level checker for the waypoint pose interpolator, with its bind.
`default_nettype none
`include "waypoint_pose_interpolator_unit_macros.svh"
module wpi_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_result_valid,
    input wire logic o_pose_valid,
    input wire logic o_traj_active,
    input wire logic o_traj_running
);
    // an accepted transaction either answers next cycle or keeps the block busy
    `WPI_ASSERT_NXT(a_accept_progress, i_start && !o_busy, o_busy || o_result_valid)
    // a long tick finishes by dropping busy as its result appears
    `WPI_ASSERT_IMP(a_strobe_idle, o_result_valid, !o_busy)
    // a fresh pose only exists inside a run
    `WPI_ASSERT_IMP(a_valid_in_run, o_pose_valid, o_traj_running)
    // running implies active; in the design the two rise and fall together
    `WPI_ASSERT_IMP(a_active_run, o_traj_running, o_traj_active)
endmodule

bind waypoint_pose_interpolator_unit wpi_chk u_wpi_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_pose_valid   (o_pose_valid),
    .o_traj_active  (o_traj_active),
    .o_traj_running (o_traj_running)
);
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the waypoint pose interpolator unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import wpi_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int TARGET_ITEMS = 1350;

    typedef struct {
        logic signed [20:0] x, y, z;
        logic signed [15:0] roll, pitch, yaw;
        logic               pvalid, active, running;
    } t_pose;

    typedef struct {
        t_cmd               cmd;
        logic [8:0]         idx;
        logic signed [20:0] x, y, z;
        logic signed [15:0] roll, pitch, yaw;
        logic [15:0]        dur;
        bit                 typed;
        logic [2:0]         flags;  // pose_valid, traj_active, traj_running
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [1:0]         i_cmd = CMD_TICK;
    logic [8:0]         i_wp_index = '0;
    logic signed [20:0] i_wp_x = '0, i_wp_y = '0, i_wp_z = '0;
    logic signed [15:0] i_wp_roll = '0, i_wp_pitch = '0, i_wp_yaw = '0;
    logic [15:0]        i_wp_duration_ms = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_PERIOD;
    logic [9:0]         i_cfg_data = '0;
    logic               o_result_valid;
    logic signed [20:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [15:0] o_ang_roll, o_ang_pitch, o_ang_yaw;
    logic               o_pose_valid, o_traj_active, o_traj_running;

    waypoint_pose_interpolator_unit i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: waypoint store, sequencer position, held pose, registers
    int    wp_pos [WP_MAX][3];
    int    wp_ang [WP_MAX][3];
    int    wp_dur [WP_MAX];
    bit    wp_loaded [WP_MAX];
    int    seg, step_cnt;
    int    hold_pos [3];
    int    hold_ang [3];
    bit    f_valid, f_active, f_running;
    int    period_ms, wp_count;

    t_pose pose_q[$];
    int    n_errors = 0;
    int    n_items = 0;
    int    burst_left = 0;
    longint cycles = 0;

    // a + floor((b - a) * t / 65536)
    function automatic int lerp(int a, int b, longint t);
        longint prod, q;
        prod = (longint'(b) - longint'(a)) * t;
        if (prod >= 0) q = prod / 65536;
        else q = -((-prod + 65535) / 65536);
        return int'(longint'(a) + q);
    endfunction

    function automatic void advance_tick();
        int cnt, per, steps;
        longint t;
        cnt = (wp_count > WP_MAX) ? WP_MAX : wp_count;
        per = (period_ms == 0) ? 1 : period_ms;
        if (cnt < 2 || seg + 1 >= cnt) begin
            {f_valid, f_active, f_running} = 3'b000;
            return;
        end
        steps = wp_dur[seg + 1] / per;
        if (steps == 0) steps = 1;
        t = (longint'(step_cnt) * 65536) / steps;
        for (int k = 0; k < 3; k++) begin
            hold_pos[k] = lerp(wp_pos[seg][k], wp_pos[seg + 1][k], t);
            hold_ang[k] = lerp(wp_ang[seg][k], wp_ang[seg + 1][k], t);
        end
        f_valid = 1'b1;
        if (step_cnt >= steps) begin
            step_cnt = 0;
            seg++;
        end else begin
            step_cnt++;
        end
    endfunction

    // Apply one accepted command and return the pose it leaves on the outputs
    function automatic t_pose next_pose(t_row r);
        t_pose p;
        case (r.cmd)
            CMD_TICK: if (f_running) advance_tick();
            CMD_START: if (!f_running) begin
                {f_valid, f_active, f_running} = 3'b011;
                seg = 0;
                step_cnt = 0;
            end
            CMD_STOP: {f_valid, f_active, f_running} = 3'b000;
            CMD_LOAD: if (!f_running) begin
                wp_pos[r.idx] = '{int'(r.x), int'(r.y), int'(r.z)};
                wp_ang[r.idx] = '{int'(r.roll), int'(r.pitch), int'(r.yaw)};
                wp_dur[r.idx] = int'(r.dur);
                wp_loaded[r.idx] = 1'b1;
            end
        endcase
        p.x = 21'(hold_pos[0]);
        p.y = 21'(hold_pos[1]);
        p.z = 21'(hold_pos[2]);
        p.roll = 16'(hold_ang[0]);
        p.pitch = 16'(hold_ang[1]);
        p.yaw = 16'(hold_ang[2]);
        {p.pvalid, p.active, p.running} = {f_valid, f_active, f_running};
        return p;
    endfunction

    task automatic report(string field, longint got, longint want);
        n_errors++;
        $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
    endtask

    // Compare each strobed result with the oldest expected pose
    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n && o_result_valid) begin
            if (pose_q.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                e = pose_q.pop_front();
                if (o_pos_x !== e.x) report("pos_x", o_pos_x, e.x);
                if (o_pos_y !== e.y) report("pos_y", o_pos_y, e.y);
                if (o_pos_z !== e.z) report("pos_z", o_pos_z, e.z);
                if (o_ang_roll !== e.roll) report("ang_roll", o_ang_roll, e.roll);
                if (o_ang_pitch !== e.pitch) report("ang_pitch", o_ang_pitch, e.pitch);
                if (o_ang_yaw !== e.yaw) report("ang_yaw", o_ang_yaw, e.yaw);
                if (o_pose_valid !== e.pvalid) report("pose_valid", o_pose_valid, e.pvalid);
                if (o_traj_active !== e.active) report("traj_active", o_traj_active, e.active);
                if (o_traj_running !== e.running)
                    report("traj_running", o_traj_running, e.running);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    // Issue one command, with bursts and random gaps between them
    task automatic send(t_row r);
        t_pose p;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(3) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_start <= 1'b1;
        i_cmd <= r.cmd;
        i_wp_index <= r.idx;
        i_wp_x <= r.x;
        i_wp_y <= r.y;
        i_wp_z <= r.z;
        i_wp_roll <= r.roll;
        i_wp_pitch <= r.pitch;
        i_wp_yaw <= r.yaw;
        i_wp_duration_ms <= r.dur;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        p = next_pose(r);
        if (r.typed) begin
            p = '{x: 0, y: 0, z: 0, roll: 0, pitch: 0, yaw: 0,
                  pvalid: r.flags[2], active: r.flags[1], running: r.flags[0]};
        end
        pose_q.push_back(p);
        n_items++;
    endtask

    // Let the block go quiet before touching the registers
    task automatic drain();
        i_start <= 1'b0;
        burst_left = 0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[9:0];
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_PERIOD) period_ms = value & 10'h3FF;
        else wp_count = value & 10'h3FF;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_row plain(t_cmd c);
        t_row r;
        r = '{cmd: c, idx: 0, x: 0, y: 0, z: 0, roll: 0, pitch: 0, yaw: 0, dur: 0,
              typed: 0, flags: 0};
        return r;
    endfunction

    function automatic t_row rand_load(int idx, int per);
        t_row r;
        r = plain(CMD_LOAD);
        r.idx = 9'(idx);
        r.x = 21'(int'($urandom_range(2000000)) - 1000000);
        r.y = 21'(int'($urandom_range(2000000)) - 1000000);
        r.z = 21'(int'($urandom_range(2000000)) - 1000000);
        r.roll = 16'($urandom_range(65535));
        r.pitch = 16'($urandom_range(65535));
        r.yaw = 16'($urandom_range(65535));
        // mostly a handful of ticks per segment, sometimes any duration
        if ($urandom_range(7) == 0) r.dur = 16'($urandom_range(65535));
        else r.dur = 16'(per * int'($urandom_range(0, 5)) + int'($urandom_range(0, per)));
        return r;
    endfunction

    t_row dir_rows[$];

    initial begin
        t_row r;
        int cnt, per, n_ticks, phase;
        period_ms = 50;
        wp_count = 0;
        seg = 0;
        step_cnt = 0;
        hold_pos = '{0, 0, 0};
        hold_ang = '{0, 0, 0};
        {f_valid, f_active, f_running} = 3'b000;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: idle commands, load extremes, start and load during a run
        r = plain(CMD_TICK); r.typed = 1; r.flags = 3'b000; dir_rows.push_back(r);
        r = plain(CMD_STOP); r.typed = 1; r.flags = 3'b000; dir_rows.push_back(r);
        r = plain(CMD_START); r.typed = 1; r.flags = 3'b011; dir_rows.push_back(r);
        r = rand_load(5, 50); r.typed = 1; r.flags = 3'b011; dir_rows.push_back(r);
        r = plain(CMD_START); r.typed = 1; r.flags = 3'b011; dir_rows.push_back(r);
        // fewer than two waypoints: the tick ends the run
        r = plain(CMD_TICK); r.typed = 1; r.flags = 3'b000; dir_rows.push_back(r);
        r = '{cmd: CMD_LOAD, idx: 0, x: -1000000, y: -1000000, z: -1000000,
              roll: -32768, pitch: -32768, yaw: -32768, dur: 0, typed: 1, flags: 0};
        dir_rows.push_back(r);
        r = '{cmd: CMD_LOAD, idx: 1, x: 1000000, y: 1000000, z: 1000000,
              roll: 32767, pitch: 32767, yaw: 32767, dur: 16'hFFFF, typed: 1, flags: 0};
        dir_rows.push_back(r);
        r = '{cmd: CMD_LOAD, idx: 511, x: 1000000, y: -1000000, z: 0,
              roll: 32767, pitch: -32768, yaw: 0, dur: 16'hFFFF, typed: 1, flags: 0};
        dir_rows.push_back(r);
        r = '{cmd: CMD_LOAD, idx: 2, x: 0, y: 0, z: 0,
              roll: 0, pitch: 0, yaw: 0, dur: 0, typed: 1, flags: 0};
        dir_rows.push_back(r);
        r = plain(CMD_STOP); r.typed = 1; r.flags = 3'b000; dir_rows.push_back(r);
        r = plain(CMD_START); r.typed = 1; r.flags = 3'b011; dir_rows.push_back(r);
        r = plain(CMD_STOP); r.typed = 1; r.flags = 3'b000; dir_rows.push_back(r);
        r = plain(CMD_TICK); r.typed = 1; r.flags = 3'b000; dir_rows.push_back(r);
        foreach (dir_rows[i]) send(dir_rows[i]);

        // Random runs, each under its own register setting
        phase = 0;
        while (n_items < TARGET_ITEMS) begin
            drain();
            case (phase)
                0: begin per = 0; cnt = 2; end      // period zero acts as one
                1: begin per = 1000; cnt = 3; end
                2: begin per = 1; cnt = 512; end
                3: begin per = 1023; cnt = 1023; end // count saturates
                4: begin per = 50; cnt = 0; end
                5: begin per = 7; cnt = 1; end
                default: begin
                    per = ($urandom_range(4) == 0) ? $urandom_range(1023)
                                                   : $urandom_range(1, 60);
                    cnt = ($urandom_range(9) == 0) ? $urandom_range(0, 1)
                                                   : $urandom_range(2, 8);
                end
            endcase
            write_reg(CFG_PERIOD, per);
            write_reg(CFG_COUNT, cnt);
            per = (per == 0) ? 1 : per;
            // a run left over from the last phase would block the loads
            send(plain(CMD_STOP));
            // make sure every waypoint the run reads has been loaded
            for (int i = 0; i < ((cnt > WP_MAX) ? WP_MAX : cnt); i++)
                if (!wp_loaded[i] || (i < 10 && $urandom_range(1) == 0))
                    send(rand_load(i, per));
            if ($urandom_range(2) == 0) send(rand_load($urandom_range(511), per));
            send(plain(CMD_START));
            n_ticks = (phase == 0) ? 4 : $urandom_range(1, 6 + 6 * ((cnt > 8) ? 8 : cnt));
            for (int i = 0; i < n_ticks; i++) begin
                case ($urandom_range(19))
                    0: send(plain(CMD_START));
                    1: send(rand_load($urandom_range(511), per));
                    2: if ($urandom_range(3) == 0) send(plain(CMD_STOP));
                    default: send(plain(CMD_TICK));
                endcase
            end
            send(plain($urandom_range(1) ? CMD_STOP : CMD_TICK));
            phase++;
        end
        drain();

        if (n_errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
